// File: sv/htd_pkg.sv
// ============================================================================
// htd_pkg
// Shared types and constants of the tree-table Huffman decoder.
// ============================================================================
`default_nettype none

package htd_pkg;

    // Default number of tree nodes in the node table.
    localparam int NODE_COUNT_DEF = 256;

    localparam int BYTE_W      = 8;
    localparam int ENTRY_W     = 2 * BYTE_W;
    localparam int SYM_CNT_W   = 16;
    localparam int BIT_IDX_W   = 3;

    localparam logic [SYM_CNT_W-1:0] SYMBOLS_RESET = 16'd768;
    localparam logic [BIT_IDX_W-1:0] LAST_BIT_IDX  = 3'd7;

    // Input item codes.
    localparam logic OP_WRITE_NODE = 1'b0;
    localparam logic OP_DATA_BYTE  = 1'b1;

    typedef logic [ENTRY_W-1:0] htd_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_STEP,
        ST_FLUSH
    } htd_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_byte;
        logic write_node;
        logic issue;
        logic step;
        logic flush;
    } htd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic leaf;
        logic image_done;
        logic last_bit;
        logic pend_valid;
        logic out_free;
    } htd_status_t;

endpackage

`default_nettype wire

// File: sv/htd_ctrl.sv
// ============================================================================
// htd_ctrl
// Controller state machine: sequences node writes, the per-bit tree walk
// and the final flush of the held-back symbol of each byte.
// ============================================================================
`default_nettype none

module htd_ctrl
    import htd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        op,
    input  wire htd_status_t status,
    output logic             in_stall,
    output htd_cmd_t         cmd
);

    htd_state_t state_reg;
    htd_state_t state_next;
    logic       hold;

    // A new symbol cannot be taken while the held one has nowhere to go.
    assign hold = status.leaf && status.pend_valid && !status.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (op == OP_DATA_BYTE))
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (!hold && (status.image_done || status.last_bit))
                begin
                    if (status.leaf || status.pend_valid)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall       = 1'b0;
                cmd.load_byte  = in_valid && (op == OP_DATA_BYTE);
                cmd.write_node = in_valid && (op == OP_WRITE_NODE);
            end
            ST_ISSUE:
            begin
                cmd.issue = 1'b1;
            end
            ST_STEP:
            begin
                cmd.step = !hold;
            end
            ST_FLUSH:
            begin
                cmd.flush = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/htd_datapath.sv
// ============================================================================
// htd_datapath
// Node table memory, tree-walk registers, symbol counter and output register.
// ============================================================================
`default_nettype none

module htd_datapath
    import htd_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire htd_cmd_t              cmd,
    output htd_status_t                status,
    input  wire logic [BYTE_W-1:0]     node_index,
    input  wire logic [BYTE_W-1:0]     child_zero,
    input  wire logic [BYTE_W-1:0]     child_one,
    input  wire logic [BYTE_W-1:0]     data_byte,
    input  wire logic                  cfg_wr_en,
    input  wire logic [SYM_CNT_W-1:0]  cfg_wr_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [BYTE_W-1:0]          symbol,
    output logic                       image_end,
    output logic                       last
);

    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam logic [BYTE_W:0] NODE_LIMIT = (BYTE_W + 1)'(NODE_COUNT);

    htd_entry_t node_mem [NODE_COUNT];

    htd_entry_t              rd_data_reg;
    logic                    rd_oor_reg;
    logic                    rd_en;
    logic [BYTE_W-1:0]       rd_addr;
    htd_entry_t              entry_sel;
    logic                    bit_sel;
    logic                    wr_in_range;

    htd_entry_t              root_entry_reg, root_entry_next;
    htd_entry_t              cur_entry_reg, cur_entry_next;
    logic [BYTE_W-1:0]       cur_node_reg, cur_node_next;
    logic [BYTE_W-1:0]       next_node_reg;
    logic [BYTE_W-1:0]       byte_reg;
    logic [BIT_IDX_W-1:0]    bit_idx_reg, bit_idx_next;
    logic [BIT_IDX_W-1:0]    bit_idx_inc;
    logic [SYM_CNT_W-1:0]    symbols_done_reg, symbols_done_next;
    logic [SYM_CNT_W-1:0]    spi_reg;

    logic                    pend_valid_reg, pend_valid_next;
    logic [BYTE_W-1:0]       pend_sym_reg;
    logic                    pend_end_reg;

    logic                    out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]       symbol_reg;
    logic                    image_end_reg;
    logic                    last_reg;
    logic                    out_load;
    logic                    out_last;

    htd_entry_t              child;
    logic                    leaf;
    logic                    end_hit;
    logic [SYM_CNT_W:0]      done_inc;

    // Child entry of the node reached by the current bit; out of range reads 0/0.
    assign child   = rd_oor_reg ? '0 : rd_data_reg;
    assign leaf    = (child[BYTE_W-1:0] == child[ENTRY_W-1:BYTE_W]);
    assign done_inc = {1'b0, symbols_done_reg} + (SYM_CNT_W + 1)'(1);
    assign end_hit = (done_inc >= {1'b0, spi_reg});

    assign bit_idx_inc = bit_idx_reg + BIT_IDX_W'(1);
    assign wr_in_range = ({1'b0, node_index} < NODE_LIMIT);

    // Table read address for the next bit of the walk.
    always_comb
    begin
        if (cmd.issue)
        begin
            entry_sel = cur_entry_reg;
            bit_sel   = byte_reg[0];
        end
        else
        begin
            entry_sel = leaf ? root_entry_reg : child;
            bit_sel   = byte_reg[bit_idx_inc];
        end
        rd_addr = bit_sel ? entry_sel[ENTRY_W-1:BYTE_W] : entry_sel[BYTE_W-1:0];
        rd_en   = cmd.issue || cmd.step;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_node && wr_in_range)
        begin
            node_mem[node_index[AW-1:0]] <= {child_one, child_zero};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg   <= node_mem[rd_addr[AW-1:0]];
            rd_oor_reg    <= ({1'b0, rd_addr} >= NODE_LIMIT);
            next_node_reg <= rd_addr;
        end
    end

    always_comb
    begin
        root_entry_next   = root_entry_reg;
        cur_entry_next    = cur_entry_reg;
        cur_node_next     = cur_node_reg;
        bit_idx_next      = bit_idx_reg;
        symbols_done_next = symbols_done_reg;
        pend_valid_next   = pend_valid_reg;
        out_load          = 1'b0;
        out_last          = 1'b0;

        if (cmd.write_node && wr_in_range)
        begin
            if (node_index == '0)
            begin
                root_entry_next = {child_one, child_zero};
            end
            if (node_index == cur_node_reg)
            begin
                cur_entry_next = {child_one, child_zero};
            end
        end

        if (cmd.load_byte)
        begin
            bit_idx_next = '0;
        end

        if (cmd.step)
        begin
            bit_idx_next = bit_idx_inc;
            if (leaf)
            begin
                // The previous symbol of this byte is now known not to be last.
                out_load          = pend_valid_reg;
                pend_valid_next   = 1'b1;
                cur_node_next     = '0;
                cur_entry_next    = root_entry_reg;
                symbols_done_next = end_hit ? '0 : done_inc[SYM_CNT_W-1:0];
            end
            else
            begin
                cur_node_next  = next_node_reg;
                cur_entry_next = child;
            end
        end

        if (cmd.flush)
        begin
            out_load        = 1'b1;
            out_last        = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_entry_reg   <= '0;
            cur_entry_reg    <= '0;
            cur_node_reg     <= '0;
            bit_idx_reg      <= '0;
            symbols_done_reg <= '0;
            spi_reg          <= SYMBOLS_RESET;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            root_entry_reg   <= root_entry_next;
            cur_entry_reg    <= cur_entry_next;
            cur_node_reg     <= cur_node_next;
            bit_idx_reg      <= bit_idx_next;
            symbols_done_reg <= symbols_done_next;
            pend_valid_reg   <= pend_valid_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_wr_en)
            begin
                spi_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_byte)
        begin
            byte_reg <= data_byte;
        end
        if (cmd.step && leaf)
        begin
            pend_sym_reg <= child[BYTE_W-1:0];
            pend_end_reg <= end_hit;
        end
        if (out_load)
        begin
            symbol_reg    <= pend_sym_reg;
            image_end_reg <= pend_end_reg;
            last_reg      <= out_last;
        end
    end

    always_comb
    begin
        status.leaf       = leaf;
        status.image_done = leaf && end_hit;
        status.last_bit   = (bit_idx_reg == LAST_BIT_IDX);
        status.pend_valid = pend_valid_reg;
        status.out_free   = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;
    assign image_end = image_end_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

// File: sv/huffman_tree_table_decoder.sv
// ============================================================================
// huffman_tree_table_decoder
// Huffman decoder that walks a flattened tree held in an on-chip node table.
// ============================================================================
// The tree is loaded with node-write beats (op 0); each node holds two child
// indices, and a node whose two children are equal is a leaf carrying that
// value as its symbol. Data beats (op 1) carry one compressed byte, walked
// least significant bit first, one table read per bit through the single read
// port of the node table; the walk keeps the current node's entry in a
// register. A node-write beat leaves the decoder idle and ready for the next
// beat. A data beat occupies the decoder while it accepts the byte, issues
// the first read, walks one to eight bits, and sends the final symbol of the
// byte, which is held back until the byte is finished so that its last flag
// is known. A byte that completes no symbol skips that final send. The
// decoder is held up further only while the output side stalls. After
// symbols_per_image symbols an image ends, the walk returns to the root and
// the rest of that byte is dropped. The register is to be written by the user
// through cfg_wr_en and cfg_wr_data while the decoder is idle; the decoder
// itself does not enforce this.
// Nodes that were never written must not be reached by the tree walk.
// ============================================================================
`default_nettype none

module huffman_tree_table_decoder
    import htd_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // Input channel.
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  op,
    input  wire logic [BYTE_W-1:0]     node_index,
    input  wire logic [BYTE_W-1:0]     child_zero,
    input  wire logic [BYTE_W-1:0]     child_one,
    input  wire logic [BYTE_W-1:0]     data_byte,

    // Configuration: symbols_per_image.
    input  wire logic                  cfg_wr_en,
    input  wire logic [SYM_CNT_W-1:0]  cfg_wr_data,

    // Output channel.
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [BYTE_W-1:0]          symbol,
    output logic                       image_end,
    output logic                       last
);

    htd_cmd_t    cmd;
    htd_status_t status;

    // The controller only sequences; all state of the walk lives in the datapath.
    htd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // The datapath owns the node table, the symbol counter and the output
    // register, which lets a finished symbol wait while the walk continues.
    htd_datapath #(
        .NODE_COUNT (NODE_COUNT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .node_index  (node_index),
        .child_zero  (child_zero),
        .child_one   (child_one),
        .data_byte   (data_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .symbol      (symbol),
        .image_end   (image_end),
        .last        (last)
    );

endmodule

`default_nettype wire
